// ----- rtl/bqpi_pkg.sv -----
package bqpi_pkg;

  // Width of the fields of one input word and one result word.
  localparam int unsigned OpcodeW   = 3;
  localparam int unsigned ValueW    = 8;
  localparam int unsigned PositionW = 5;
  localparam int unsigned CountW    = 5;
  localparam int unsigned StatusW   = 2;

  typedef enum logic [OpcodeW-1:0] {
    OPC_ENQUEUE   = 3'd0,
    OPC_DEQUEUE   = 3'd1,
    OPC_INS_FRONT = 3'd2,
    OPC_INS_POS   = 3'd3,
    OPC_CLEAR     = 3'd4
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE          = 2'd0,
    ST_FULL_DROP     = 2'd1,
    ST_EMPTY_IGNORED = 2'd2
  } status_e;

  // What the datapath does to the queue on the accepting edge.
  typedef enum logic [1:0] {
    DOP_HOLD   = 2'd0,
    DOP_INSERT = 2'd1,
    DOP_REMOVE = 2'd2,
    DOP_CLEAR  = 2'd3
  } dp_op_e;

  // Where an insert lands.
  typedef enum logic [1:0] {
    PSEL_REAR  = 2'd0,
    PSEL_FRONT = 2'd1,
    PSEL_INDEX = 2'd2
  } pos_sel_e;

  typedef enum logic {
    CS_IDLE   = 1'b0,
    CS_RESULT = 1'b1
  } ctl_state_e;

  typedef struct packed {
    logic     exec;
    dp_op_e   op;
    pos_sel_e pos_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_sts_t;

endpackage

// ----- rtl/bqpi_if.sv -----
interface bqpi_in_if
  import bqpi_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OpcodeW-1:0]   opcode;
  logic [ValueW-1:0]    value;
  logic [PositionW-1:0] position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

interface bqpi_out_if
  import bqpi_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ValueW-1:0]   head_value;
  logic                is_empty;
  logic [CountW-1:0]   entry_count;
  logic [StatusW-1:0]  status;

  modport source (output valid, output head_value, output is_empty, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input head_value, input is_empty, input entry_count,
                  input status, output ready);
endinterface

// ----- rtl/bqpi_datapath.sv -----
module bqpi_datapath
  import bqpi_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  input  logic [ValueW-1:0]    value_i,
  input  logic [PositionW-1:0] position_i,
  output dp_sts_t              sts_o,
  output logic [ValueW-1:0]    head_value_o,
  output logic                 is_empty_o,
  output logic [CountW-1:0]    entry_count_o
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = OccW + PositionW;

  logic [ValueW-1:0] entries_q [DEPTH];
  logic [ValueW-1:0] entries_d [DEPTH];
  logic [OccW-1:0]   occ_q, occ_d;
  logic [CmpW-1:0]   occ_ext, pos_ext, idx;
  logic [CmpW-1:0]   cnt_ext;

  assign occ_ext = {{PositionW{1'b0}}, occ_q};
  assign pos_ext = {{OccW{1'b0}}, position_i};

  assign sts_o.full  = (occ_q == OccW'(DEPTH));
  assign sts_o.empty = (occ_q == '0);

  // Target slot of an insert; positions past the tail append at the rear.
  always_comb begin
    case (cmd_i.pos_sel)
      PSEL_FRONT: idx = '0;
      PSEL_INDEX: idx = (pos_ext < occ_ext) ? pos_ext : occ_ext;
      default:    idx = occ_ext;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [CmpW-1:0] SlotIdx = CmpW'(i);
    always_comb begin
      entries_d[i] = entries_q[i];
      if (cmd_i.exec) begin
        case (cmd_i.op)
          DOP_INSERT: begin
            if (SlotIdx == idx) begin
              entries_d[i] = value_i;
            end else if (SlotIdx > idx) begin
              entries_d[i] = (i > 0) ? entries_q[(i > 0) ? i - 1 : 0] : entries_q[i];
            end
          end
          DOP_REMOVE: begin
            entries_d[i] = (i < DEPTH - 1) ? entries_q[(i < DEPTH - 1) ? i + 1 : i] :
                                             entries_q[i];
          end
          default: entries_d[i] = entries_q[i];
        endcase
      end
    end
  end

  always_comb begin
    occ_d = occ_q;
    if (cmd_i.exec) begin
      case (cmd_i.op)
        DOP_INSERT: occ_d = occ_q + OccW'(1);
        DOP_REMOVE: occ_d = occ_q - OccW'(1);
        DOP_CLEAR:  occ_d = '0;
        default:    occ_d = occ_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entries_q <= entries_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign cnt_ext       = {{PositionW{1'b0}}, occ_q};
  assign entry_count_o = cnt_ext[CountW-1:0];
  assign is_empty_o    = sts_o.empty;
  assign head_value_o  = sts_o.empty ? '0 : entries_q[0];

`ifndef NO_ASSERTIONS
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(DEPTH))
    else $error("occupancy exceeds queue depth");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && cmd_i.op == DOP_CLEAR |=> occ_q == '0)
    else $error("clear did not empty the queue");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && cmd_i.op == DOP_INSERT |=> occ_q == $past(occ_q) + OccW'(1))
    else $error("insert did not add one entry");
`endif

endmodule

// ----- rtl/bqpi_controller.sv -----
module bqpi_controller
  import bqpi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpcodeW-1:0] opcode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  input  dp_sts_t            sts_i,
  output dp_cmd_t            cmd_o
);

  ctl_state_e state_q, state_d;
  status_e    status_q, status_d;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
  end

  always_comb begin
    in_ready_o  = (state_q == CS_IDLE) || out_ready_i;
    out_valid_o = (state_q == CS_RESULT);
    accept      = in_valid_i && in_ready_o;

    cmd_o.exec    = accept;
    cmd_o.op      = DOP_HOLD;
    cmd_o.pos_sel = PSEL_REAR;
    status_d      = status_q;

    if (accept) begin
      status_d = ST_DONE;
      case (opcode_i)
        OPC_ENQUEUE, OPC_INS_FRONT, OPC_INS_POS: begin
          if (sts_i.full) begin
            status_d = ST_FULL_DROP;
          end else begin
            cmd_o.op = DOP_INSERT;
          end
          if (opcode_i == OPC_INS_FRONT) begin
            cmd_o.pos_sel = PSEL_FRONT;
          end else if (opcode_i == OPC_INS_POS) begin
            cmd_o.pos_sel = PSEL_INDEX;
          end
        end
        OPC_DEQUEUE: begin
          if (sts_i.empty) begin
            status_d = ST_EMPTY_IGNORED;
          end else begin
            cmd_o.op = DOP_REMOVE;
          end
        end
        OPC_CLEAR: cmd_o.op = DOP_CLEAR;
        default:   cmd_o.op = DOP_HOLD;
      endcase
    end

    case (state_q)
      CS_IDLE:   state_d = accept ? CS_RESULT : CS_IDLE;
      CS_RESULT: state_d = (accept || !out_ready_i) ? CS_RESULT : CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  assign status_o = status_q;

`ifndef NO_ASSERTIONS
  a_no_insert_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec && cmd_o.op == DOP_INSERT |-> !sts_i.full)
    else $error("insert issued to a full queue");

  a_no_remove_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec && cmd_o.op == DOP_REMOVE |-> !sts_i.empty)
    else $error("remove issued to an empty queue");

  a_accept_gives_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word produced no result");
`endif

endmodule

// ----- rtl/byte_queue_with_positional_insert_unit.sv -----
// The result word of an accepted word is valid in the cycle after acceptance.
// One word is taken per cycle while the result side takes each result as it appears;
// the single result register holds off the next word only while a result is stalled.
// Every queue operation, including an insert in the middle, is done on the accepting
// edge by the shifting register chain. Reset clears the entry count and the handshake state;
// the byte storage itself is not cleared and needs no clearing pass.
module byte_queue_with_positional_insert_unit
  import bqpi_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bqpi_in_if.sink       in_i,
  bqpi_out_if.source    out_o
);

  // Command and status travel between the control FSM and the queue datapath.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller owns the handshake and the status code. It decodes the opcode
  // against the full and empty flags, so a dropped insert or an ignored dequeue
  // never reaches the storage.
  bqpi_controller u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .opcode_i    (in_i.opcode),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_o    (out_o.status),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the bytes as a chain of registers, head at slot zero.
  // Inserts shift the slots behind the target one place toward the rear and
  // a dequeue shifts every slot one place toward the head. Head, empty flag and
  // count are read straight from the stored state, which stays put while a
  // result waits because no new word is taken in that time.
  bqpi_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (in_i.value),
    .position_i    (in_i.position),
    .sts_o         (sts),
    .head_value_o  (out_o.head_value),
    .is_empty_o    (out_o.is_empty),
    .entry_count_o (out_o.entry_count)
  );

endmodule

// ----- tb/testbench.sv -----
module testbench
  import bqpi_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned RandomWords = 650;
  localparam int unsigned CycleLimit  = 200000;

  // Opcodes the block treats as no operation.
  localparam logic [OpcodeW-1:0] OpcSpareLo  = 3'd5;
  localparam logic [OpcodeW-1:0] OpcSpareMid = 3'd6;
  localparam logic [OpcodeW-1:0] OpcSpareHi  = 3'd7;

  // One result word as the block reports it.
  typedef struct packed {
    logic [ValueW-1:0] head;
    logic              empty;
    logic [CountW-1:0] count;
    status_e           status;
  } result_t;

  // One row of the directed part. A row with a repeat count sends that many
  // words, the value going up by one each time. When typed is set, the row's
  // result is known in advance and stands in the row; otherwise the queue
  // predictor supplies it.
  typedef struct packed {
    logic [OpcodeW-1:0]   op;
    logic [ValueW-1:0]    val;
    logic [PositionW-1:0] pos;
    logic [4:0]           reps;
    logic                 typed;
    result_t              want;
  } plan_row_t;

  localparam result_t NoWant = '{8'h00, 1'b0, 5'd0, ST_DONE};
  localparam result_t FullDrop = '{8'h3c, 1'b0, 5'd16, ST_FULL_DROP};
  localparam result_t EmptyDone = '{8'h00, 1'b1, 5'd0, ST_DONE};

  localparam int unsigned PlanRows = 24;
  localparam plan_row_t DirectedPlan [PlanRows] = '{
    // Dequeue from the empty queue right after reset is ignored.
    '{OPC_DEQUEUE,   8'h00, 5'd0,  5'd1,  1'b1, '{8'h00, 1'b1, 5'd0, ST_EMPTY_IGNORED}},
    // A zero byte at the head must not look like an empty queue.
    '{OPC_ENQUEUE,   8'h00, 5'd0,  5'd1,  1'b1, '{8'h00, 1'b0, 5'd1, ST_DONE}},
    '{OPC_ENQUEUE,   8'hff, 5'd31, 5'd1,  1'b0, NoWant},
    '{OPC_INS_FRONT, 8'ha5, 5'd0,  5'd1,  1'b1, '{8'ha5, 1'b0, 5'd3, ST_DONE}},
    '{OPC_DEQUEUE,   8'hff, 5'd31, 5'd1,  1'b0, NoWant},
    // Inserts in the middle, past the end, and exactly at the depth.
    '{OPC_INS_POS,   8'h5a, 5'd1,  5'd1,  1'b0, NoWant},
    '{OPC_INS_POS,   8'h81, 5'd31, 5'd1,  1'b0, NoWant},
    '{OPC_INS_POS,   8'h7e, 5'd16, 5'd1,  1'b0, NoWant},
    '{OPC_INS_POS,   8'h3c, 5'd0,  5'd1,  1'b1, '{8'h3c, 1'b0, 5'd6, ST_DONE}},
    // Spare opcodes leave the queue alone.
    '{OpcSpareLo,    8'hff, 5'd31, 5'd1,  1'b0, NoWant},
    '{OpcSpareMid,   8'h00, 5'd0,  5'd1,  1'b0, NoWant},
    '{OpcSpareHi,    8'h55, 5'd10, 5'd1,  1'b0, NoWant},
    // Fill up to the depth.
    '{OPC_ENQUEUE,   8'h10, 5'd0,  5'd10, 1'b0, NoWant},
    // Every kind of insert is dropped while full.
    '{OPC_ENQUEUE,   8'hee, 5'd0,  5'd1,  1'b1, FullDrop},
    '{OPC_INS_FRONT, 8'hdd, 5'd0,  5'd1,  1'b1, FullDrop},
    '{OPC_INS_POS,   8'hcc, 5'd3,  5'd1,  1'b1, FullDrop},
    // Insert at the last index, then at the count itself.
    '{OPC_DEQUEUE,   8'h00, 5'd0,  5'd1,  1'b0, NoWant},
    '{OPC_INS_POS,   8'h99, 5'd14, 5'd1,  1'b0, NoWant},
    '{OPC_DEQUEUE,   8'h00, 5'd0,  5'd1,  1'b0, NoWant},
    '{OPC_INS_POS,   8'h66, 5'd15, 5'd1,  1'b0, NoWant},
    // Clear from full, and clear of an empty queue.
    '{OPC_CLEAR,     8'hff, 5'd31, 5'd1,  1'b1, EmptyDone},
    '{OPC_CLEAR,     8'h00, 5'd0,  5'd1,  1'b1, EmptyDone},
    // Positional insert into an empty queue lands at the head.
    '{OPC_INS_POS,   8'h42, 5'd7,  5'd1,  1'b1, '{8'h42, 1'b0, 5'd1, ST_DONE}},
    '{OPC_DEQUEUE,   8'h00, 5'd0,  5'd1,  1'b1, EmptyDone}
  };

  logic clk_i;
  logic rst_ni;

  bqpi_in_if  in_bus ();
  bqpi_out_if out_bus ();

  byte_queue_with_positional_insert_unit #(
    .DEPTH (QueueDepth)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // The predictor's own copy of the queue: index 0 is the head.
  logic [ValueW-1:0] q_bytes [QueueDepth];
  int unsigned       q_count;

  // Results that accepted words have yet to produce, oldest first.
  result_t pending_results [$];

  int unsigned error_count;
  int unsigned cycle_count;

  // While quiet is set, neither side idles or stalls.
  bit quiet;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Applies one queue operation to the predictor state and returns the
  // result word the block should report for it.
  function automatic result_t apply_queue_op(input logic [OpcodeW-1:0] op,
                                             input logic [ValueW-1:0] val,
                                             input logic [PositionW-1:0] pos);
    result_t     res;
    int unsigned slot;
    res = NoWant;
    case (op)
      OPC_ENQUEUE, OPC_INS_FRONT, OPC_INS_POS: begin
        if (q_count >= QueueDepth) begin
          res.status = ST_FULL_DROP;
        end else begin
          if (op == OPC_ENQUEUE) begin
            slot = q_count;
          end else if (op == OPC_INS_FRONT) begin
            slot = 0;
          end else begin
            slot = pos;
          end
          // A position at or past the count means append at the rear.
          if (slot > q_count) begin
            slot = q_count;
          end
          for (int unsigned i = q_count; i > slot; i--) begin
            q_bytes[i] = q_bytes[i-1];
          end
          q_bytes[slot] = val;
          q_count++;
        end
      end
      OPC_DEQUEUE: begin
        if (q_count == 0) begin
          res.status = ST_EMPTY_IGNORED;
        end else begin
          for (int unsigned i = 1; i < q_count; i++) begin
            q_bytes[i-1] = q_bytes[i];
          end
          q_count--;
        end
      end
      OPC_CLEAR: begin
        q_count = 0;
      end
      default: begin
      end
    endcase
    res.head  = (q_count > 0) ? q_bytes[0] : 8'h00;
    res.empty = (q_count == 0);
    res.count = q_count[CountW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // Offers one word to the block. It is entered just after a falling edge and
  // returns just after the falling edge that follows acceptance. Every drive
  // happens at a falling edge, one assignment per signal per edge, so valid
  // stays high straight into the next word when no idle cycle is drawn.
  task automatic send_word(input logic [OpcodeW-1:0] op, input logic [ValueW-1:0] val,
                           input logic [PositionW-1:0] pos, input bit typed,
                           input result_t want);
    result_t predicted;
    while (!quiet && $urandom_range(99) < 7) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= op;
    in_bus.value    <= val;
    in_bus.position <= pos;
    do begin
      @(posedge clk_i);
    end while (!in_bus.ready);
    // The predictor runs for every accepted word so that its state tracks
    // the block; a typed row only replaces what is expected.
    predicted = apply_queue_op(op, val, pos);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // Random opcode mix. Filling leans toward inserts so that the queue runs
  // into full often; draining leans toward dequeues so that it reaches empty.
  function automatic logic [OpcodeW-1:0] pick_opcode(input bit filling);
    int unsigned roll;
    roll = $urandom_range(99);
    if (filling) begin
      if (roll < 35) return OPC_ENQUEUE;
      if (roll < 55) return OPC_INS_FRONT;
      if (roll < 85) return OPC_INS_POS;
      if (roll < 95) return OPC_DEQUEUE;
      if (roll < 97) return OPC_CLEAR;
    end else begin
      if (roll < 60) return OPC_DEQUEUE;
      if (roll < 72) return OPC_ENQUEUE;
      if (roll < 80) return OPC_INS_FRONT;
      if (roll < 93) return OPC_INS_POS;
      if (roll < 96) return OPC_CLEAR;
    end
    return OpcSpareLo + OpcodeW'($urandom_range(OpcSpareHi - OpcSpareLo));
  endfunction

  // Result side: ready is redrawn at every falling edge, low with a chance of about seven
  // in a hundred except during the quiet stretch.
  always @(negedge clk_i) begin
    out_bus.ready <= quiet || ($urandom_range(99) >= 7);
  end

  // Check each result word taken by the handshake against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.head   = out_bus.head_value;
      got.empty  = out_bus.is_empty;
      got.count  = out_bus.entry_count;
      got.status = status_e'(out_bus.status);
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected, count", got.count, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.head !== want.head) report_mismatch("head_value", got.head, want.head);
        if (got.empty !== want.empty) report_mismatch("is_empty", got.empty, want.empty);
        if (got.count !== want.count) report_mismatch("entry_count", got.count, want.count);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [OpcodeW-1:0]   op;
    logic [ValueW-1:0]    val;
    logic [PositionW-1:0] pos;
    bit                   filling;

    error_count     = 0;
    cycle_count     = 0;
    quiet           = 1'b0;
    filling         = 1'b1;
    q_count         = 0;
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.opcode   = OPC_ENQUEUE;
    in_bus.value    = '0;
    in_bus.position = '0;
    out_bus.ready   = 1'b0;

    // Reset is applied once and released on a falling edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: walk the plan table.
    for (int unsigned row = 0; row < PlanRows; row++) begin
      for (int unsigned rep = 0; rep < DirectedPlan[row].reps; rep++) begin
        send_word(DirectedPlan[row].op, DirectedPlan[row].val + rep[ValueW-1:0],
                  DirectedPlan[row].pos, DirectedPlan[row].typed, DirectedPlan[row].want);
      end
    end

    // Random part. The mode flips between filling and draining so that the
    // queue swings between empty and full many times; positions mostly fall
    // inside the queue, the rest anywhere in the field.
    for (int unsigned n = 0; n < RandomWords; n++) begin
      quiet = (n >= 300) && (n < 450);
      if (q_count == QueueDepth && $urandom_range(99) < 25) begin
        filling = 1'b0;
      end else if (q_count == 0) begin
        filling = 1'b1;
      end else if ($urandom_range(99) < 2) begin
        filling = !filling;
      end
      op  = pick_opcode(filling);
      val = ValueW'($urandom_range(255));
      if ($urandom_range(99) < 30) begin
        pos = PositionW'($urandom_range(31));
      end else begin
        pos = PositionW'($urandom_range(q_count));
      end
      send_word(op, val, pos, 1'b0, NoWant);
    end
    quiet = 1'b0;
    in_bus.valid <= 1'b0;

    // Drain: wait for every expected word, then keep watching a while longer so that a
    // stray word can still show up.
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bqpi_pkg.sv
rtl/bqpi_if.sv
rtl/bqpi_datapath.sv
rtl/bqpi_controller.sv
rtl/byte_queue_with_positional_insert_unit.sv
tb/testbench.sv
